// File: rtl/owb_pkg.sv
package owb_pkg;

    localparam int COUNT_BITS = 10;

    localparam int PHASE_BITS = 3;
    localparam logic [PHASE_BITS-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_RST_LOW   = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_RST_WAIT  = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_RST_END   = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_SLOT_LOW  = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_SLOT_WAIT = 3'd5;
    localparam logic [PHASE_BITS-1:0] PH_SLOT_END  = 3'd6;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_RESET   = 3'd1;
    localparam logic [2:0] MODE_TOUCH   = 3'd2;
    localparam logic [2:0] MODE_PWR_ON  = 3'd3;
    localparam logic [2:0] MODE_PWR_OFF = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DEVICE = 2'd1;
    localparam logic [1:0] ST_NO_POWER  = 2'd2;

    localparam logic [1:0] REG_OVERDRIVE       = 2'd0;
    localparam logic [1:0] REG_OPEN_DRAIN      = 2'd1;
    localparam logic [1:0] REG_PWR_PIN_PRESENT = 2'd2;
    localparam logic [1:0] REG_PWR_PIN_ACT_HI  = 2'd3;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic overdrive;
        logic open_drain_data;
        logic power_pin_present;
        logic power_pin_active_high;
    } t_cfg;

    typedef struct packed {
        logic [2:0] mode;
        logic       send_bit;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       pull_low;
        logic       drive_high;
        logic       power_pin;
        logic       busy_res;
        logic       done_res;
        logic       result_bit;
        logic [1:0] status;
    } t_result;

    // Length in ticks of a phase under the current timing selection.
    function automatic t_count phase_len(logic [PHASE_BITS-1:0] ph, logic od, logic wo);
        t_count len;
        len = '0;
        unique case (ph)
            PH_RST_LOW:   len = od ? t_count'(68) : t_count'(480);
            PH_RST_WAIT:  len = od ? t_count'(8)  : t_count'(70);
            PH_RST_END:   len = od ? t_count'(40) : t_count'(410);
            PH_SLOT_LOW:  len = wo ? (od ? t_count'(1) : t_count'(5))
                                   : (od ? t_count'(8) : t_count'(60));
            PH_SLOT_WAIT: len = wo ? (od ? t_count'(1) : t_count'(8)) : t_count'(0);
            PH_SLOT_END:  len = wo ? (od ? t_count'(7) : t_count'(56))
                                   : (od ? t_count'(1) : t_count'(10));
            default:      len = '0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/owb_cfg.sv
module owb_cfg
    import owb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic       i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OVERDRIVE:       r_cfg.overdrive             <= i_cfg_data;
                REG_OPEN_DRAIN:      r_cfg.open_drain_data       <= i_cfg_data;
                REG_PWR_PIN_PRESENT: r_cfg.power_pin_present     <= i_cfg_data;
                REG_PWR_PIN_ACT_HI:  r_cfg.power_pin_active_high <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/owb_seq.sv
module owb_seq
    import owb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    t_count                r_count, n_count;
    logic                  r_sampled, n_sampled;
    logic                  r_write_one, n_write_one;
    logic                  r_power_on, n_power_on;

    always_comb begin
        logic       supported;
        logic       reads;
        logic       use_pin;
        t_count     len;
        t_result    res;

        supported = !i_cfg.open_drain_data || i_cfg.power_pin_present;
        res       = '0;
        reads     = 1'b0;
        len       = '0;

        n_phase     = (r_phase > PH_SLOT_END) ? PH_IDLE : r_phase;
        n_count     = r_count;
        n_sampled   = r_sampled;
        n_write_one = r_write_one;
        n_power_on  = r_power_on;

        if (n_phase == PH_IDLE) begin
            if (i_item.mode == MODE_RESET || i_item.mode == MODE_TOUCH) begin
                // drop strong pullup at the start of every sequence, when the pullup is supported
                if (supported) begin
                    n_power_on = 1'b0;
                end
                n_phase     = (i_item.mode == MODE_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
                n_write_one = (i_item.mode == MODE_TOUCH) ? i_item.send_bit : 1'b0;
                n_count     = '0;
                n_sampled   = 1'b0;
            end else if (i_item.mode == MODE_PWR_ON || i_item.mode == MODE_PWR_OFF) begin
                res.done_res = 1'b1;
                if (supported) begin
                    n_power_on = (i_item.mode == MODE_PWR_ON);
                end else begin
                    res.status = ST_NO_POWER;
                end
            end
        end

        if (n_phase != PH_IDLE) begin
            len          = phase_len(n_phase, i_cfg.overdrive, n_write_one);
            res.busy_res = 1'b1;
            res.pull_low = (n_phase == PH_RST_LOW) || (n_phase == PH_SLOT_LOW);
            if ((n_phase == PH_RST_END || n_phase == PH_SLOT_END) && n_count == '0) begin
                reads     = (n_phase == PH_RST_END) || n_write_one;
                n_sampled = reads & i_item.line_level;
            end
            n_count = n_count + t_count'(1);
            if (n_count >= len) begin
                n_count = '0;
                unique case (n_phase)
                    PH_RST_LOW:   n_phase = PH_RST_WAIT;
                    PH_RST_WAIT:  n_phase = PH_RST_END;
                    PH_SLOT_LOW:  n_phase = (phase_len(PH_SLOT_WAIT, i_cfg.overdrive,
                                             n_write_one) != '0) ? PH_SLOT_WAIT : PH_SLOT_END;
                    PH_SLOT_WAIT: n_phase = PH_SLOT_END;
                    PH_RST_END: begin
                        res.done_res = 1'b1;
                        res.status   = n_sampled ? ST_NO_DEVICE : ST_OK;
                        n_phase      = PH_IDLE;
                    end
                    default: begin
                        res.done_res   = 1'b1;
                        res.result_bit = n_sampled;
                        n_phase        = PH_IDLE;
                    end
                endcase
            end
        end

        use_pin        = n_power_on & i_cfg.open_drain_data & i_cfg.power_pin_present;
        res.drive_high = n_power_on & !i_cfg.open_drain_data;
        res.power_pin  = i_cfg.power_pin_active_high ? use_pin : !use_pin;
        o_result       = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_sampled   <= 1'b0;
            r_write_one <= 1'b0;
            r_power_on  <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_sampled   <= n_sampled;
            r_write_one <= n_write_one;
            r_power_on  <= n_power_on;
        end
    end

endmodule

// File: rtl/one_wire_bus_master.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_mode, i_send_bit, i_line_level
// result    out        o_out_valid / i_out_ready o_pull_low .. o_status
// config    in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One tick per clock while results drain; a tick passes the input, then the result register.
// The rate is set by the single timer update between the input and result registers.
// Reset (synchronous, active low) clears the timer, power state and configuration.
// A stalled result holds the result register; the input register still takes one more tick,
// and the input side stalls only when both registers are full.
module one_wire_bus_master
    import owb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_mode,
    input  logic       i_send_bit,
    input  logic       i_line_level,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_pull_low,
    output logic       o_drive_high,
    output logic       o_power_pin,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_result_bit,
    output logic [1:0] o_status
);

    t_cfg    cfg;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result r_out, seq_result;
    logic    r_out_valid;
    logic    advance;

    owb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // move the held tick into the result register when it is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    owb_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item.mode       <= i_mode;
            r_in_item.send_bit   <= i_send_bit;
            r_in_item.line_level <= i_line_level;
        end
        if (advance) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pull_low   = r_out.pull_low;
    assign o_drive_high = r_out.drive_high;
    assign o_power_pin  = r_out.power_pin;
    assign o_busy_res   = r_out.busy_res;
    assign o_done_res   = r_out.done_res;
    assign o_result_bit = r_out.result_bit;
    assign o_status     = r_out.status;

endmodule
